FILE: sv/lupp_pkg.sv
// Shared types and constants for the LU elimination block.
package lupp_pkg;

  localparam int DATA_W = 32;
  localparam int QUO_W  = 48;
  localparam int DIVCNT_W = 6;
  localparam logic signed [DATA_W-1:0] Q_ONE   = 32'sh0001_0000;
  localparam logic signed [DATA_W-1:0] Q_MAX   = 32'sh7FFF_FFFF;
  localparam logic signed [DATA_W-1:0] Q_MIN   = 32'sh8000_0000;
  localparam logic [2:0]               SIZE_RST = 3'd4;

  // Matrix selector on the result stream
  localparam logic MAT_U = 1'b0;
  localparam logic MAT_P = 1'b1;

  typedef enum logic [4:0] {
    S_LOAD, S_INIT, S_PRD, S_PCMP, S_PDEC,
    S_SWR1, S_SWR2, S_SWW1, S_SWW2,
    S_PVR, S_PVC, S_RRD, S_RCK, S_DIV,
    S_URA, S_URB, S_UMUL, S_UTRN, S_UADD, S_NXJ,
    S_ERD, S_ECAP, S_EOUT
  } state_e;

  // Request into the shared divider
  typedef struct packed {
    logic              start;
    logic [QUO_W-1:0]  dividend;
    logic [DATA_W-1:0] divisor;
  } div_req_t;

  // Answer from the shared divider
  typedef struct packed {
    logic             done;
    logic [QUO_W-1:0] quot;
  } div_rsp_t;

endpackage

FILE: sv/lupp_div.sv
// Restoring divider, unsigned magnitudes, one quotient bit per cycle.
module lupp_div
  import lupp_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  div_req_t req_i,
  output div_rsp_t rsp_o
);

  logic              busy_q, busy_d;
  logic              done_q, done_d;
  logic [DIVCNT_W-1:0] cnt_q, cnt_d;
  logic [DATA_W:0]   rem_q, rem_d;
  logic [QUO_W-1:0]  quo_q, quo_d;
  logic [DATA_W-1:0] dvs_q, dvs_d;
  logic [DATA_W:0]   rem_sh;

  // Load on start, else one shift-subtract step
  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    quo_d  = quo_q;
    dvs_d  = dvs_q;
    rem_sh = {rem_q[DATA_W-1:0], quo_q[QUO_W-1]};
    if (req_i.start) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      rem_d  = '0;
      quo_d  = req_i.dividend;
      dvs_d  = req_i.divisor;
    end else if (busy_q) begin
      if (rem_sh >= {1'b0, dvs_q}) begin
        rem_d = rem_sh - {1'b0, dvs_q};
        quo_d = {quo_q[QUO_W-2:0], 1'b1};
      end else begin
        rem_d = rem_sh;
        quo_d = {quo_q[QUO_W-2:0], 1'b0};
      end
      cnt_d = cnt_q + 1'b1;
      if (cnt_q == DIVCNT_W'(QUO_W - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
    dvs_q <= dvs_d;
  end

  assign rsp_o.done = done_q;
  assign rsp_o.quot = quo_q;

endmodule

FILE: sv/lu_elimination_partial_pivot_top.sv
// LU elimination with partial pivoting: load, sequencer, shared divide/multiply, emit.
// Load: one element per cycle, none while cfg_we_i is set; the run starts after element n*n.
// Run: sets P to identity; pivot column i: search of rows i..n-1, row swap in A when needed;
//   per row below it: skipped when its entry is zero, else one run of the 48-step divider
//   and an update per element (n-i-1 in U, n in the product); no input is taken meanwhile.
// Emit: 2*n*n results, U then P, each read, registered and held while the output is stalled.
// Reset (async, active low) clears control and sets the size to 4; matrices undefined.
module lu_elimination_partial_pivot_top
  import lupp_pkg::*;
#(
  parameter int MAX_ORDER = 4
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     cfg_we_i,
  input  logic [2:0]               cfg_wdata_i,
  input  logic                     in_valid_i,
  output logic                     in_stall_o,
  input  logic signed [DATA_W-1:0] element_value_i,
  output logic                     out_valid_o,
  input  logic                     out_stall_i,
  output logic signed [DATA_W-1:0] result_value_o,
  output logic                     which_matrix_o,
  output logic [1:0]               row_index_o,
  output logic [1:0]               col_index_o,
  output logic                     status_o,
  output logic [1:0]               failed_column_o,
  output logic                     last_result_o
);

  localparam int CW    = $clog2(MAX_ORDER + 1);
  localparam int DEPTH = MAX_ORDER * MAX_ORDER;
  localparam int AW    = $clog2(DEPTH);

  function automatic logic [AW-1:0] addr_f(logic [CW-1:0] r, logic [CW-1:0] c);
    return AW'(int'(r) * MAX_ORDER + int'(c));
  endfunction

  function automatic logic [DATA_W-1:0] mag_f(logic signed [DATA_W-1:0] x);
    return x[DATA_W-1] ? (~x + 1'b1) : x;
  endfunction

  state_e state_q, state_d;

  logic [2:0]    size_q;
  logic [CW-1:0] n, nm1;
  logic [CW-1:0] ld_r_q, ld_c_q, i_q, j_q, k_q, best_q, er_q, ec_q, failcol_q;
  logic          w_q, selp_q, stat_q;
  logic [DATA_W-1:0]        bestmag_q;
  logic signed [DATA_W-1:0] pv_q, v_q, d_q, x_q, y_q, t_q, tmp_q;
  logic signed [2*DATA_W-1:0] prod_q;

  logic                     out_valid_q, out_w_q, out_last_q;
  logic signed [DATA_W-1:0] out_val_q;
  logic [CW-1:0]            out_r_q, out_c_q;

  // Memories
  logic signed [DATA_W-1:0] a_mem [DEPTH];
  logic signed [DATA_W-1:0] p_mem [DEPTH];
  logic signed [DATA_W-1:0] a_rd_q, p_rd_q, sel_rd;
  logic                     a_we, p_we;
  logic [AW-1:0]            waddr, raddr;
  logic signed [DATA_W-1:0] wdata;

  div_req_t div_req;
  div_rsp_t div_rsp;

  logic          in_acc, ld_last, emit_last;
  logic [DATA_W-1:0] mag_rd;
  logic signed [QUO_W-1:0]   trunc_v;
  logic signed [DATA_W:0]    sum_v;
  logic signed [DATA_W-1:0]  sum_sat, d_sat;

  // Effective order
  always_comb begin
    if (size_q == 3'd0) n = CW'(1);
    else if (int'(size_q) > MAX_ORDER) n = CW'(MAX_ORDER);
    else n = CW'(size_q);
    nm1 = n - 1'b1;
  end

  assign in_stall_o = (state_q != S_LOAD);
  assign in_acc     = in_valid_i && !in_stall_o;
  assign ld_last    = (ld_r_q == nm1) && (ld_c_q == nm1);
  assign emit_last  = w_q && (er_q == nm1) && (ec_q == nm1);
  assign sel_rd     = selp_q ? p_rd_q : a_rd_q;
  assign mag_rd     = mag_f(a_rd_q);

  // Quotient sign and saturation: d = -v / pv
  always_comb begin
    if ((!v_q[DATA_W-1]) ^ pv_q[DATA_W-1]) begin
      if (div_rsp.quot > QUO_W'(64'h8000_0000)) d_sat = Q_MIN;
      else d_sat = DATA_W'(~div_rsp.quot[DATA_W-1:0] + 1'b1);
    end else begin
      if (div_rsp.quot > QUO_W'(64'h7FFF_FFFF)) d_sat = Q_MAX;
      else d_sat = div_rsp.quot[DATA_W-1:0];
    end
  end

  // Product scaled back toward zero, then saturated sum
  always_comb begin
    if (prod_q[2*DATA_W-1]) trunc_v = QUO_W'((prod_q + 64'sd65535) >>> 16);
    else trunc_v = QUO_W'(prod_q >>> 16);
    sum_v = {y_q[DATA_W-1], y_q} + {t_q[DATA_W-1], t_q};
    if (sum_v[DATA_W] != sum_v[DATA_W-1]) sum_sat = sum_v[DATA_W] ? Q_MIN : Q_MAX;
    else sum_sat = sum_v[DATA_W-1:0];
  end

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_LOAD: if (in_acc && ld_last && !cfg_we_i) state_d = S_INIT;
      S_INIT: if (er_q == nm1 && ec_q == nm1) state_d = (n == CW'(1)) ? S_ERD : S_PRD;
      S_PRD:  state_d = S_PCMP;
      S_PCMP: state_d = (j_q == nm1) ? S_PDEC : S_PRD;
      S_PDEC: begin
        if (bestmag_q == '0) state_d = S_ERD;
        else if (best_q != i_q) state_d = S_SWR1;
        else state_d = S_PVR;
      end
      S_SWR1: state_d = S_SWR2;
      S_SWR2: state_d = S_SWW1;
      S_SWW1: state_d = S_SWW2;
      S_SWW2: state_d = (k_q == nm1) ? S_PVR : S_SWR1;
      S_PVR:  state_d = S_PVC;
      S_PVC:  state_d = S_RRD;
      S_RRD:  state_d = S_RCK;
      S_RCK:  state_d = (a_rd_q == '0) ? S_NXJ : S_DIV;
      S_DIV:  if (div_rsp.done) state_d = S_URA;
      S_URA:  state_d = S_URB;
      S_URB:  state_d = S_UMUL;
      S_UMUL: state_d = S_UTRN;
      S_UTRN: state_d = S_UADD;
      S_UADD: state_d = (k_q == nm1 && selp_q) ? S_NXJ : S_URA;
      S_NXJ: begin
        if (j_q != nm1) state_d = S_RRD;
        else if (i_q + 1'b1 == nm1) state_d = S_ERD;
        else state_d = S_PRD;
      end
      S_ERD:  state_d = S_ECAP;
      S_ECAP: state_d = S_EOUT;
      S_EOUT: if (!out_stall_i) state_d = emit_last ? S_LOAD : S_ERD;
      default: state_d = S_LOAD;
    endcase
  end

  // Memory and divider controls
  always_comb begin
    a_we    = 1'b0;
    p_we    = 1'b0;
    waddr   = addr_f(j_q, k_q);
    wdata   = sum_sat;
    raddr   = addr_f(i_q, k_q);
    div_req = '0;
    case (state_q)
      S_LOAD: begin
        a_we  = in_acc && !cfg_we_i;
        waddr = addr_f(ld_r_q, ld_c_q);
        wdata = element_value_i;
      end
      S_INIT: begin
        p_we  = 1'b1;
        waddr = addr_f(er_q, ec_q);
        wdata = (er_q == ec_q) ? Q_ONE : '0;
      end
      S_PRD:  raddr = addr_f(j_q, i_q);
      S_SWR1: raddr = addr_f(i_q, k_q);
      S_SWR2: raddr = addr_f(best_q, k_q);
      S_SWW1: begin
        a_we  = 1'b1;
        waddr = addr_f(i_q, k_q);
        wdata = a_rd_q;
      end
      S_SWW2: begin
        a_we  = 1'b1;
        waddr = addr_f(best_q, k_q);
        wdata = tmp_q;
      end
      S_PVR:  raddr = addr_f(i_q, i_q);
      S_RRD:  raddr = addr_f(j_q, i_q);
      S_RCK: begin
        div_req.start    = (a_rd_q != '0);
        div_req.dividend = {mag_rd, 16'h0000};
        div_req.divisor  = mag_f(pv_q);
      end
      S_DIV: begin
        a_we  = div_rsp.done;
        waddr = addr_f(j_q, i_q);
        wdata = '0;
      end
      S_URA:  raddr = addr_f(i_q, k_q);
      S_URB:  raddr = addr_f(j_q, k_q);
      S_UADD: begin
        a_we  = !selp_q;
        p_we  = selp_q;
        waddr = addr_f(j_q, k_q);
        wdata = sum_sat;
      end
      S_ERD:  raddr = addr_f(er_q, ec_q);
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (a_we) a_mem[waddr] <= wdata;
    if (p_we) p_mem[waddr] <= wdata;
    a_rd_q <= a_mem[raddr];
    p_rd_q <= p_mem[raddr];
  end

  lupp_div u_div (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .req_i (div_req),
    .rsp_o (div_rsp)
  );

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_LOAD;
      size_q      <= SIZE_RST;
      ld_r_q      <= '0;
      ld_c_q      <= '0;
      i_q         <= '0;
      j_q         <= '0;
      k_q         <= '0;
      best_q      <= '0;
      er_q        <= '0;
      ec_q        <= '0;
      w_q         <= 1'b0;
      selp_q      <= 1'b0;
      stat_q      <= 1'b0;
      failcol_q   <= '0;
      bestmag_q   <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      case (state_q)
        S_LOAD: begin
          if (cfg_we_i) begin
            size_q <= cfg_wdata_i;
            ld_r_q <= '0;
            ld_c_q <= '0;
          end else if (in_acc) begin
            if (ld_c_q == nm1) begin
              ld_c_q <= '0;
              ld_r_q <= ld_last ? '0 : ld_r_q + 1'b1;
            end else begin
              ld_c_q <= ld_c_q + 1'b1;
            end
            er_q <= '0;
            ec_q <= '0;
          end
        end
        S_INIT: begin
          if (ec_q == nm1) begin
            ec_q <= '0;
            er_q <= (er_q == nm1) ? '0 : er_q + 1'b1;
          end else begin
            ec_q <= ec_q + 1'b1;
          end
          i_q       <= '0;
          j_q       <= '0;
          best_q    <= '0;
          bestmag_q <= '0;
          w_q       <= MAT_U;
          stat_q    <= 1'b0;
          failcol_q <= '0;
        end
        S_PCMP: begin
          if (mag_rd > bestmag_q) begin
            bestmag_q <= mag_rd;
            best_q    <= j_q;
          end
          if (j_q != nm1) j_q <= j_q + 1'b1;
        end
        S_PDEC: begin
          k_q <= '0;
          if (bestmag_q == '0) begin
            stat_q    <= 1'b1;
            failcol_q <= i_q;
          end
        end
        S_SWW2: if (k_q != nm1) k_q <= k_q + 1'b1;
        S_PVC:  j_q <= i_q + 1'b1;
        S_DIV: begin
          k_q    <= i_q + 1'b1;
          selp_q <= 1'b0;
        end
        S_UADD: begin
          if (k_q == nm1) begin
            k_q    <= '0;
            selp_q <= 1'b1;
          end else begin
            k_q <= k_q + 1'b1;
          end
        end
        S_NXJ: begin
          if (j_q != nm1) begin
            j_q <= j_q + 1'b1;
          end else begin
            i_q       <= i_q + 1'b1;
            j_q       <= i_q + 1'b1;
            best_q    <= i_q + 1'b1;
            bestmag_q <= '0;
          end
        end
        S_ECAP: out_valid_q <= 1'b1;
        S_EOUT: begin
          if (!out_stall_i) begin
            out_valid_q <= 1'b0;
            if (ec_q == nm1) begin
              ec_q <= '0;
              if (er_q == nm1) begin
                er_q <= '0;
                w_q  <= ~w_q;
              end else begin
                er_q <= er_q + 1'b1;
              end
            end else begin
              ec_q <= ec_q + 1'b1;
            end
          end
        end
        default: ;
      endcase
    end
  end

  // Datapath registers
  always_ff @(posedge clk_i) begin
    case (state_q)
      S_SWR2: tmp_q  <= a_rd_q;
      S_PVC:  pv_q   <= a_rd_q;
      S_RCK:  v_q    <= a_rd_q;
      S_DIV:  if (div_rsp.done) d_q <= d_sat;
      S_URB:  x_q    <= sel_rd;
      S_UMUL: begin
        prod_q <= x_q * d_q;
        y_q    <= sel_rd;
      end
      S_UTRN: begin
        if (trunc_v[QUO_W-1:DATA_W-1] == '0 || trunc_v[QUO_W-1:DATA_W-1] == '1)
          t_q <= trunc_v[DATA_W-1:0];
        else
          t_q <= trunc_v[QUO_W-1] ? Q_MIN : Q_MAX;
      end
      S_ECAP: begin
        out_val_q  <= w_q ? p_rd_q : a_rd_q;
        out_w_q    <= w_q;
        out_r_q    <= er_q;
        out_c_q    <= ec_q;
        out_last_q <= emit_last;
      end
      default: ;
    endcase
  end

  assign out_valid_o     = out_valid_q;
  assign result_value_o  = out_val_q;
  assign which_matrix_o  = out_w_q;
  assign row_index_o     = 2'(out_r_q);
  assign col_index_o     = 2'(out_c_q);
  assign status_o        = stat_q;
  assign failed_column_o = 2'(failcol_q);
  assign last_result_o   = out_last_q;

  // Checks
  a_out_only_emit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> (state_q == S_EOUT))
    else $error("result shown outside emit");

  a_no_in_during_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |-> !out_valid_q)
    else $error("item taken while results pending");

  a_div_to_update: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DIV && div_rsp.done) |=> (state_q == S_URA))
    else $error("divider result not followed by row update");

  a_no_write_emit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_EOUT || state_q == S_ERD || state_q == S_ECAP) |-> !(a_we || p_we))
    else $error("matrix written during emit");

endmodule
